// ----- src/mcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared constants, types and the arctangent table of the motion command
// shaper.
// ----------------------------------------------------------------------------
`default_nettype none
package mcs_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CNT_W        = $clog2(CORDIC_STEPS);

    // Rotator datapath widths: vector scaled by 256, angle in 1/2^24 turn.
    localparam int XW = 27;
    localparam int ZW = 26;

    // Shared multiplier operand widths.
    localparam int MA_W = 29;
    localparam int MB_W = 24;
    localparam int MP_W = MA_W + MB_W;

    localparam logic [16:0] CORDIC_GAIN_Q16 = 17'd39797;
    localparam logic [18:0] TWO_PI_Q16      = 19'd411775;

    // Configuration register indexes.
    localparam logic [2:0] REG_MAX_SPEED      = 3'd0;
    localparam logic [2:0] REG_MAX_SPEED_STEP = 3'd1;
    localparam logic [2:0] REG_MAX_TURN_RATE  = 3'd2;
    localparam logic [2:0] REG_MAX_TURN_STEP  = 3'd3;
    localparam logic [2:0] REG_GAIN_BASE      = 3'd4;
    localparam logic [2:0] REG_GAIN_SPEED     = 3'd5;

    typedef logic signed [XW-1:0] t_cvec;

    // Arctangent of 2^-i in 1/2^24 turn.
    function automatic logic [21:0] atan_entry(input logic [4:0] i);
        logic [21:0] v;
        begin
            case (i)
                5'd0:    v = 22'd2097152;
                5'd1:    v = 22'd1238021;
                5'd2:    v = 22'd654136;
                5'd3:    v = 22'd332050;
                5'd4:    v = 22'd166669;
                5'd5:    v = 22'd83416;
                5'd6:    v = 22'd41718;
                5'd7:    v = 22'd20860;
                5'd8:    v = 22'd10430;
                5'd9:    v = 22'd5215;
                5'd10:   v = 22'd2608;
                5'd11:   v = 22'd1304;
                5'd12:   v = 22'd652;
                5'd13:   v = 22'd326;
                5'd14:   v = 22'd163;
                5'd15:   v = 22'd81;
                5'd16:   v = 22'd41;
                5'd17:   v = 22'd20;
                5'd18:   v = 22'd10;
                5'd19:   v = 22'd5;
                5'd20:   v = 22'd3;
                5'd21:   v = 22'd1;
                5'd22:   v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// ----- src/mcs_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none
module mcs_mul (
    input  wire                                  i_clk,
    input  wire                                  i_en,
    input  wire logic signed [mcs_pkg::MA_W-1:0] i_a,
    input  wire logic signed [mcs_pkg::MB_W-1:0] i_b,
    output logic signed [mcs_pkg::MP_W-1:0]      o_p
);

    logic signed [mcs_pkg::MP_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= mcs_pkg::MP_W'(i_a) * mcs_pkg::MP_W'(i_b);
        end
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

// ----- src/mcs_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_cordic
// Iterative CORDIC rotator, one micro-rotation per cycle, unscaled output.
// ----------------------------------------------------------------------------
`default_nettype none
module mcs_cordic (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire logic signed [17:0] i_x,
    input  wire logic signed [17:0] i_y,
    input  wire logic signed [15:0] i_ang,
    output logic                  o_done,
    output mcs_pkg::t_cvec        o_x,
    output mcs_pkg::t_cvec        o_y
);

    localparam int XW = mcs_pkg::XW;
    localparam int ZW = mcs_pkg::ZW;
    localparam int CW = mcs_pkg::CNT_W;

    logic signed [XW-1:0] r_x, r_y, n_x, n_y, x0, y0, dx, dy;
    logic signed [ZW-1:0] r_z, n_z, z0, at;
    logic [CW-1:0]        r_i;
    logic                 r_busy, r_done;

    always_comb begin
        x0 = XW'(i_x) <<< 8;
        y0 = XW'(i_y) <<< 8;
        z0 = ZW'(i_ang) <<< 8;
        // Angles beyond a quarter turn are brought back by a half turn.
        if (i_ang > 16'sd16384) begin
            x0 = -x0;
            y0 = -y0;
            z0 = z0 - (ZW'(1) <<< 23);
        end else if (i_ang < -16'sd16384) begin
            x0 = -x0;
            y0 = -y0;
            z0 = z0 + (ZW'(1) <<< 23);
        end
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        at = $signed(ZW'(mcs_pkg::atan_entry(5'(r_i))));
        if (r_z >= 0) begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - at;
        end else begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= x0;
                r_y    <= y0;
                r_z    <= z0;
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                if (r_i == CW'(mcs_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule
`default_nettype wire

// ----- src/mcs_sqdiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_sqdiv
// Shift-subtract unit: integer square root (two bits per cycle) or
// restoring division (one quotient bit per cycle).
// ----------------------------------------------------------------------------
`default_nettype none
module mcs_sqdiv (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire              i_is_div,
    input  wire logic [33:0] i_num,
    input  wire logic [16:0] i_den,
    output logic             o_done,
    output logic [16:0]      o_result
);

    logic [33:0] r_v, r_r, n_v, n_r, bitv, t;
    logic [17:0] rs;
    logic [16:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy, r_div, r_done;

    always_comb begin
        bitv = 34'd1 << {r_cnt, 1'b0};
        t    = r_r + bitv;
        rs   = {r_r[16:0], r_v[31]};
        if (r_div) begin
            if (rs >= {1'b0, r_den}) begin
                n_r = {16'd0, rs - {1'b0, r_den}};
                n_v = {2'b00, r_v[30:0], 1'b1};
            end else begin
                n_r = {16'd0, rs};
                n_v = {2'b00, r_v[30:0], 1'b0};
            end
        end else if (r_v >= t) begin
            n_v = r_v - t;
            n_r = (r_r >> 1) + bitv;
        end else begin
            n_v = r_v;
            n_r = r_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_div  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= i_num;
                r_r    <= '0;
                r_den  <= i_den;
                r_div  <= i_is_div;
                r_cnt  <= i_is_div ? 5'd31 : 5'd16;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_v <= n_v;
                r_r <= n_r;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_div ? r_v[16:0] : r_r[16:0];

endmodule
`default_nettype wire

// ----- src/motion_command_shaper_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_command_shaper_top
// Per-tick velocity command limiter with slew rate, built around one shared
// multiplier, a CORDIC rotator and a shift-subtract root/divide unit.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  command   i_valid / o_ready         i_target_vx ... i_current_heading
//  drive     o_valid / i_ready         o_drive_vx, o_drive_vy, o_drive_turn_rate
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// The result of an item comes soonest in body frame with the turn rate given
// and no speed limiting, and latest in world frame with heading hold and
// speed limiting; the next item is taken only once the sequencer is idle.
// The longest parts are the two 32-step divisions of the speed limiter and
// the 17-step square root in the shift-subtract unit, then the CORDIC steps.
// Reset clears the smoothed state and loads the register defaults.
// A new item may be taken while the previous result waits; the final slew
// step then holds until that result has been taken.
// ----------------------------------------------------------------------------
`default_nettype none
module motion_command_shaper_top (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire logic signed [15:0] i_target_vx,
    input  wire logic signed [15:0] i_target_vy,
    input  wire                   i_frame_is_local,
    input  wire                   i_heading_mode,
    input  wire logic signed [15:0] i_target_turn_rate,
    input  wire logic signed [15:0] i_target_heading,
    input  wire logic signed [15:0] i_current_heading,
    output logic                  o_valid,
    input  wire                   i_ready,
    output logic signed [15:0]    o_drive_vx,
    output logic signed [15:0]    o_drive_vy,
    output logic signed [15:0]    o_drive_turn_rate,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [2:0]       i_cfg_index,
    input  wire logic [15:0]      i_cfg_data
);

    localparam int MA_W = mcs_pkg::MA_W;
    localparam int MB_W = mcs_pkg::MB_W;
    localparam int MP_W = mcs_pkg::MP_W;

    // Sequencer states.
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_RSTART = 5'd1;
    localparam logic [4:0] S_RWAIT  = 5'd2;
    localparam logic [4:0] S_GX     = 5'd3;
    localparam logic [4:0] S_GY     = 5'd4;
    localparam logic [4:0] S_GW     = 5'd5;
    localparam logic [4:0] S_SQX    = 5'd6;
    localparam logic [4:0] S_SQY    = 5'd7;
    localparam logic [4:0] S_SQS    = 5'd8;
    localparam logic [4:0] S_RTW    = 5'd9;
    localparam logic [4:0] S_HG     = 5'd10;
    localparam logic [4:0] S_HG2    = 5'd11;
    localparam logic [4:0] S_HE     = 5'd12;
    localparam logic [4:0] S_HE2    = 5'd13;
    localparam logic [4:0] S_HK1    = 5'd14;
    localparam logic [4:0] S_HK2    = 5'd15;
    localparam logic [4:0] S_HK3    = 5'd16;
    localparam logic [4:0] S_LIM    = 5'd17;
    localparam logic [4:0] S_DXS    = 5'd18;
    localparam logic [4:0] S_DXW    = 5'd19;
    localparam logic [4:0] S_DYM    = 5'd20;
    localparam logic [4:0] S_DYS    = 5'd21;
    localparam logic [4:0] S_DYW    = 5'd22;
    localparam logic [4:0] S_SLEW   = 5'd23;

    // Configuration registers.
    logic [14:0] r_max_speed, r_max_speed_step, r_max_turn_rate, r_max_turn_step;
    logic [15:0] r_gain_base, r_gain_speed;

    // Item registers.
    logic [4:0]         r_state;
    logic signed [17:0] r_vx, r_vy;
    logic               r_hold;
    logic signed [15:0] r_th, r_ch;
    logic signed [29:0] r_turn;
    logic [33:0]        r_sq;
    logic [16:0]        r_speed;
    logic [21:0]        r_gain;
    logic signed [39:0] r_p1;
    logic signed [59:0] r_tacc;
    logic               r_ovalid;
    logic signed [17:0] r_svx, r_svy;
    logic signed [16:0] r_sturn;

    // Shared unit connections.
    logic                   mul_en;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] mul_p;
    logic                   cor_start, cor_done;
    mcs_pkg::t_cvec         cor_x, cor_y;
    logic                   sd_start, sd_div, sd_done;
    logic [33:0]            sd_num;
    logic [16:0]            sd_res;

    logic               accept, slew_go;
    logic signed [15:0] ang, err;
    logic [16:0]        abs_vx, abs_vy;
    logic signed [17:0] rot_res;
    logic signed [59:0] tsum;
    logic signed [16:0] tturn, lim_t;
    logic signed [18:0] dvx, dvy, stv;
    logic signed [17:0] dtn, stt;

    assign accept      = i_valid && o_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign slew_go     = (r_state == S_SLEW) && (!r_ovalid || i_ready);

    assign ang    = 16'sd0 - r_ch;
    assign err    = r_th - r_ch;
    assign abs_vx = r_vx[17] ? 17'(-r_vx) : r_vx[16:0];
    assign abs_vy = r_vy[17] ? 17'(-r_vy) : r_vy[16:0];
    // Undo CORDIC gain, rounding half up.
    assign rot_res = 18'((mul_p + (MP_W'(1) <<< 23)) >>> 24);
    assign tsum    = r_tacc + 60'(mul_p);

    mcs_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    mcs_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_x     (r_vx),
        .i_y     (r_vy),
        .i_ang   (ang),
        .o_done  (cor_done),
        .o_x     (cor_x),
        .o_y     (cor_y)
    );

    mcs_sqdiv u_sqdiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (sd_start),
        .i_is_div (sd_div),
        .i_num    (sd_num),
        .i_den    (r_speed),
        .o_done   (sd_done),
        .o_result (sd_res)
    );

    // Operand selection for the shared multiplier and unit starts.
    always_comb begin
        mul_en    = 1'b1;
        mul_a     = '0;
        mul_b     = '0;
        cor_start = 1'b0;
        sd_start  = 1'b0;
        sd_div    = 1'b0;
        sd_num    = r_sq + 34'(mul_p);
        case (r_state)
            S_RSTART: cor_start = 1'b1;
            S_GX: begin
                mul_a = MA_W'(cor_x);
                mul_b = $signed(MB_W'(mcs_pkg::CORDIC_GAIN_Q16));
            end
            S_GY: begin
                mul_a = MA_W'(cor_y);
                mul_b = $signed(MB_W'(mcs_pkg::CORDIC_GAIN_Q16));
            end
            S_SQX: begin
                mul_a = MA_W'(r_vx);
                mul_b = MB_W'(r_vx);
            end
            S_SQY: begin
                mul_a = MA_W'(r_vy);
                mul_b = MB_W'(r_vy);
            end
            S_SQS: begin
                mul_en   = 1'b0;
                sd_start = 1'b1;
            end
            S_HG: begin
                mul_a = $signed(MA_W'(r_speed));
                mul_b = $signed(MB_W'(r_gain_speed));
            end
            S_HE: begin
                mul_a = MA_W'(err);
                mul_b = $signed(MB_W'(r_gain));
            end
            S_HK1: begin
                mul_a = MA_W'(r_p1 >>> 19);
                mul_b = $signed(MB_W'(mcs_pkg::TWO_PI_Q16));
            end
            S_HK2: begin
                mul_a = $signed(MA_W'(r_p1[18:0]));
                mul_b = $signed(MB_W'(mcs_pkg::TWO_PI_Q16));
            end
            S_LIM: begin
                mul_a = $signed(MA_W'(abs_vx));
                mul_b = $signed(MB_W'(r_max_speed));
            end
            S_DYM: begin
                mul_a = $signed(MA_W'(abs_vy));
                mul_b = $signed(MB_W'(r_max_speed));
            end
            S_DXS, S_DYS: begin
                mul_en   = 1'b0;
                sd_start = 1'b1;
                sd_div   = 1'b1;
                sd_num   = 34'(mul_p);
            end
            default: mul_en = 1'b0;
        endcase
    end

    // Clamp of the turn target and the three slew steps.
    always_comb begin
        if (r_turn > $signed({15'd0, r_max_turn_rate})) begin
            tturn = $signed({2'b00, r_max_turn_rate});
        end else if (r_turn < -$signed({15'd0, r_max_turn_rate})) begin
            tturn = -$signed({2'b00, r_max_turn_rate});
        end else begin
            tturn = 17'(r_turn);
        end
        lim_t = tturn;
        dvx = 19'(r_vx) - 19'(r_svx);
        dvy = 19'(r_vy) - 19'(r_svy);
        dtn = 18'(lim_t) - 18'(r_sturn);
        stv = $signed({4'd0, r_max_speed_step});
        stt = $signed({3'd0, r_max_turn_step});
        if (dvx > stv) dvx = stv;
        else if (dvx < -stv) dvx = -stv;
        if (dvy > stv) dvy = stv;
        else if (dvy < -stv) dvy = -stv;
        if (dtn > stt) dtn = stt;
        else if (dtn < -stt) dtn = -stt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_ovalid         <= 1'b0;
            r_svx            <= '0;
            r_svy            <= '0;
            r_sturn          <= '0;
            r_max_speed      <= 15'd8192;
            r_max_speed_step <= 15'd16;
            r_max_turn_rate  <= 15'd10240;
            r_max_turn_step  <= 15'd64;
            r_gain_base      <= 16'd256;
            r_gain_speed     <= 16'd0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mcs_pkg::REG_MAX_SPEED:      r_max_speed      <= i_cfg_data[14:0];
                    mcs_pkg::REG_MAX_SPEED_STEP: r_max_speed_step <= i_cfg_data[14:0];
                    mcs_pkg::REG_MAX_TURN_RATE:  r_max_turn_rate  <= i_cfg_data[14:0];
                    mcs_pkg::REG_MAX_TURN_STEP:  r_max_turn_step  <= i_cfg_data[14:0];
                    mcs_pkg::REG_GAIN_BASE:      r_gain_base      <= i_cfg_data;
                    mcs_pkg::REG_GAIN_SPEED:     r_gain_speed     <= i_cfg_data;
                    default: ;
                endcase
            end

            // A new result takes the output register; otherwise it empties
            // once the waiting result has been taken.
            if (slew_go) begin
                r_ovalid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_vx    <= 18'(i_target_vx);
                        r_vy    <= 18'(i_target_vy);
                        r_hold  <= i_heading_mode;
                        r_th    <= i_target_heading;
                        r_ch    <= i_current_heading;
                        r_turn  <= 30'(i_target_turn_rate);
                        r_state <= i_frame_is_local ? S_SQX : S_RSTART;
                    end
                end
                S_RSTART: r_state <= S_RWAIT;
                S_RWAIT:  if (cor_done) r_state <= S_GX;
                S_GX:     r_state <= S_GY;
                S_GY: begin
                    r_vx    <= rot_res;
                    r_state <= S_GW;
                end
                S_GW: begin
                    r_vy    <= rot_res;
                    r_state <= S_SQX;
                end
                S_SQX: r_state <= S_SQY;
                S_SQY: begin
                    r_sq    <= 34'(mul_p);
                    r_state <= S_SQS;
                end
                S_SQS: r_state <= S_RTW;
                S_RTW: begin
                    if (sd_done) begin
                        r_speed <= sd_res;
                        r_state <= r_hold ? S_HG : S_LIM;
                    end
                end
                S_HG: r_state <= S_HG2;
                S_HG2: begin
                    r_gain  <= 22'(r_gain_base) + 22'(mul_p >>> 12);
                    r_state <= S_HE;
                end
                S_HE: r_state <= S_HE2;
                S_HE2: begin
                    r_p1    <= 40'(mul_p);
                    r_state <= S_HK1;
                end
                S_HK1: r_state <= S_HK2;
                S_HK2: begin
                    r_tacc  <= 60'(mul_p) <<< 19;
                    r_state <= S_HK3;
                end
                S_HK3: begin
                    r_turn  <= 30'(tsum >>> 30);
                    r_state <= S_LIM;
                end
                S_LIM: begin
                    r_state <= (r_speed > {2'b00, r_max_speed}) ? S_DXS : S_SLEW;
                end
                S_DXS: r_state <= S_DXW;
                S_DXW: begin
                    if (sd_done) begin
                        r_vx    <= r_vx[17] ? -$signed({1'b0, sd_res})
                                            : $signed({1'b0, sd_res});
                        r_state <= S_DYM;
                    end
                end
                S_DYM: r_state <= S_DYS;
                S_DYS: r_state <= S_DYW;
                S_DYW: begin
                    if (sd_done) begin
                        r_vy    <= r_vy[17] ? -$signed({1'b0, sd_res})
                                            : $signed({1'b0, sd_res});
                        r_state <= S_SLEW;
                    end
                end
                S_SLEW: begin
                    if (slew_go) begin
                        r_svx    <= 18'(19'(r_svx) + dvx);
                        r_svy    <= 18'(19'(r_svy) + dvy);
                        r_sturn  <= 17'(18'(r_sturn) + dtn);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid           = r_ovalid;
    assign o_drive_vx        = r_svx[15:0];
    assign o_drive_vy        = r_svy[15:0];
    assign o_drive_turn_rate = r_sturn[15:0];

endmodule
`default_nettype wire
